FILE: rtl/frs_pkg.sv
// Shared types, constants and binary32 arithmetic helpers for the fast
// inverse square root unit. No dependencies.

package frs_pkg;

	// Number of refinement cells in the chain
	localparam int unsigned NEWTON_STEPS = 4;

	localparam logic [31:0] MAGIC_BASE = 32'h5f3759df;
	localparam logic [31:0] F32_HALF = 32'h3f000000;
	localparam logic [31:0] F32_THREE_HALVES = 32'h3fc00000;
	localparam logic [31:0] F32_CANON_NAN = 32'h7fc00000;
	localparam logic [31:0] F32_POS_ZERO = 32'h00000000;

	// Request commands
	typedef enum logic [1:0] {
		CMD_RSQRT = 2'd0,
		CMD_RECIP = 2'd1,
		CMD_SQRT = 2'd2
	} cmd_e;

	// Operation of one arithmetic stage
	typedef enum logic {
		FOP_MUL = 1'b0,
		FOP_SUB = 1'b1
	} fop_e;

	// Context that travels with a request down the chain
	typedef struct packed {
		logic [1:0] cmd;
		logic [31:0] x;
		logic [31:0] hx;
		logic [31:0] y;
	} ctx_t;

	// Unrounded result between the two halves of an arithmetic stage
	typedef struct packed {
		logic special;
		logic [31:0] special_bits;
		logic sign;
		logic signed [11:0] ex;
		logic [47:0] sig;
	} fmid_t;

	// Classify and multiply the significands
	function automatic fmid_t fp_mul_front(logic [31:0] a, logic [31:0] b);
		fmid_t m;
		logic a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, sgn;
		logic [23:0] ma, mb;
		logic [8:0] ea, eb;
		a_nan = (a[30:23] == 8'hff) && (a[22:0] != 23'd0);
		b_nan = (b[30:23] == 8'hff) && (b[22:0] != 23'd0);
		a_inf = (a[30:23] == 8'hff) && (a[22:0] == 23'd0);
		b_inf = (b[30:23] == 8'hff) && (b[22:0] == 23'd0);
		a_zero = (a[30:0] == 31'd0);
		b_zero = (b[30:0] == 31'd0);
		sgn = a[31] ^ b[31];
		ma = {(a[30:23] != 8'd0), a[22:0]};
		mb = {(b[30:23] != 8'd0), b[22:0]};
		ea = (a[30:23] == 8'd0) ? 9'd1 : {1'b0, a[30:23]};
		eb = (b[30:23] == 8'd0) ? 9'd1 : {1'b0, b[30:23]};
		m.special = 1'b0;
		m.special_bits = F32_POS_ZERO;
		m.sign = sgn;
		m.ex = 12'(signed'({3'b000, ea})) + 12'(signed'({3'b000, eb})) - 12'sd126;
		m.sig = 48'(ma) * 48'(mb);
		if (a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero)) begin
			m.special = 1'b1;
			m.special_bits = F32_CANON_NAN;
		end else if (a_inf || b_inf) begin
			m.special = 1'b1;
			m.special_bits = {sgn, 8'hff, 23'd0};
		end else if (a_zero || b_zero) begin
			m.special = 1'b1;
			m.special_bits = {sgn, 31'd0};
		end
		return m;
	endfunction

	// Classify, align and add a - b
	function automatic fmid_t fp_sub_front(logic [31:0] a, logic [31:0] bn);
		fmid_t m;
		logic [31:0] b, big, sml;
		logic a_nan, b_nan, a_inf, b_inf;
		logic [23:0] mbig, msml;
		logic [8:0] ebig, esml;
		logic [8:0] d;
		logic [26:0] sx, bx, sh;
		logic sticky;
		logic [27:0] s;
		b = {~bn[31], bn[30:0]};
		a_nan = (a[30:23] == 8'hff) && (a[22:0] != 23'd0);
		b_nan = (b[30:23] == 8'hff) && (b[22:0] != 23'd0);
		a_inf = (a[30:23] == 8'hff) && (a[22:0] == 23'd0);
		b_inf = (b[30:23] == 8'hff) && (b[22:0] == 23'd0);
		if (a[30:0] >= b[30:0]) begin
			big = a;
			sml = b;
		end else begin
			big = b;
			sml = a;
		end
		mbig = {(big[30:23] != 8'd0), big[22:0]};
		msml = {(sml[30:23] != 8'd0), sml[22:0]};
		ebig = (big[30:23] == 8'd0) ? 9'd1 : {1'b0, big[30:23]};
		esml = (sml[30:23] == 8'd0) ? 9'd1 : {1'b0, sml[30:23]};
		d = ebig - esml;
		bx = {mbig, 3'b000};
		sx = {msml, 3'b000};
		sh = sx >> d;
		sticky = |(sx & ~({27{1'b1}} << d));
		sh[0] = sh[0] | sticky;
		if (big[31] == sml[31]) begin
			s = {1'b0, bx} + {1'b0, sh};
		end else begin
			s = {1'b0, bx} - {1'b0, sh};
		end
		m.special = 1'b0;
		m.special_bits = F32_POS_ZERO;
		m.sign = (s == 28'd0) ? (a[31] & b[31]) : big[31];
		m.ex = 12'(signed'({3'b000, ebig})) + 12'sd1;
		m.sig = {s, 20'd0};
		if (a_nan || b_nan || (a_inf && b_inf && (a[31] != b[31]))) begin
			m.special = 1'b1;
			m.special_bits = F32_CANON_NAN;
		end else if (a_inf) begin
			m.special = 1'b1;
			m.special_bits = a;
		end else if (b_inf) begin
			m.special = 1'b1;
			m.special_bits = b;
		end
		return m;
	endfunction

	// Normalize, round to nearest even and pack
	function automatic logic [31:0] fp_round(fmid_t m);
		logic [5:0] lz;
		logic [47:0] norm;
		logic signed [11:0] e;
		logic [11:0] sh;
		logic sticky, g, st;
		logic [24:0] mant;
		logic [31:0] sum;
		logic [31:0] r;
		lz = 6'd0;
		for (int i = 0; i < 48; i++) begin
			if (m.sig[i]) begin
				lz = 6'(47 - i);
			end
		end
		norm = m.sig << lz;
		e = m.ex - 12'(signed'({6'd0, lz}));
		if (e < 12'sd1) begin
			sh = 12'(12'sd1 - e);
			sticky = |(norm & ~({48{1'b1}} << sh));
			norm = norm >> sh;
			norm[0] = norm[0] | sticky;
			e = 12'sd1;
		end
		g = norm[23];
		st = |norm[22:0];
		mant = {1'b0, norm[47:24]} + {24'd0, g & (st | norm[24])};
		sum = ({24'd0, 8'(e - 12'sd1)} << 23) + {7'd0, mant};
		if (m.special) begin
			r = m.special_bits;
		end else if (m.sig == 48'd0) begin
			r = {m.sign, 31'd0};
		end else if (e >= 12'sd255) begin
			r = {m.sign, 8'hff, 23'd0};
		end else begin
			r = {m.sign, sum[30:0]};
		end
		return r;
	endfunction

endpackage

FILE: rtl/frs_if.sv
// Request and response channel interfaces of the fast inverse square root unit.
// Depends on nothing but the package-free payload widths below.

interface frs_req_if;
	logic valid;
	logic ready;
	logic [1:0] cmd;
	logic [31:0] operand_bits;

	modport source(output valid, output cmd, output operand_bits, input ready);
	modport sink(input valid, input cmd, input operand_bits, output ready);
endinterface

interface frs_rsp_if;
	logic valid;
	logic ready;
	logic [31:0] result_bits;

	modport source(output valid, output result_bits, input ready);
	modport sink(input valid, input result_bits, output ready);
endinterface

FILE: rtl/frs_fp_op.sv
// Two-stage binary32 multiply or subtract with a context that rides along.
// Depends on frs_pkg.

module frs_fp_op import frs_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic en,
	input fop_e op,
	input logic [31:0] a,
	input logic [31:0] b,
	input logic vld,
	input ctx_t ctx,
	output logic [31:0] r,
	output logic r_vld,
	output ctx_t r_ctx
);

	fmid_t mid_s1;
	ctx_t ctx_s1;
	logic vld_s1;
	logic [31:0] r_s2;
	ctx_t ctx_s2;
	logic vld_s2;

	// Hold valid bits under stall
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld;
			vld_s2 <= vld_s1;
		end
	end

	// Align or multiply, then round
	always_ff @(posedge clk) begin
		if (en) begin
			mid_s1 <= (op == FOP_SUB) ? fp_sub_front(a, b) : fp_mul_front(a, b);
			ctx_s1 <= ctx;
			r_s2 <= fp_round(mid_s1);
			ctx_s2 <= ctx_s1;
		end
	end

	assign r = r_s2;
	assign r_vld = vld_s2;
	assign r_ctx = ctx_s2;

endmodule

FILE: rtl/frs_newton_cell.sv
// One Newton refinement cell, y = y * (1.5 - hx * (y * y)), in eight stages.
// Depends on frs_pkg and frs_fp_op.

module frs_newton_cell import frs_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic vld,
	input ctx_t ctx,
	output logic nxt_vld,
	output ctx_t nxt_ctx
);

	logic [31:0] t1, t2, t3, y_new;
	logic v1, v2, v3, v4;
	ctx_t c1, c2, c3, c4;

	// Square the estimate
	frs_fp_op u_sq (
		.clk(clk), .arst_n(arst_n), .en(en), .op(FOP_MUL),
		.a(ctx.y), .b(ctx.y), .vld(vld), .ctx(ctx),
		.r(t1), .r_vld(v1), .r_ctx(c1)
	);

	// Scale by half the operand
	frs_fp_op u_hx (
		.clk(clk), .arst_n(arst_n), .en(en), .op(FOP_MUL),
		.a(c1.hx), .b(t1), .vld(v1), .ctx(c1),
		.r(t2), .r_vld(v2), .r_ctx(c2)
	);

	// Subtract from three halves
	frs_fp_op u_sub (
		.clk(clk), .arst_n(arst_n), .en(en), .op(FOP_SUB),
		.a(F32_THREE_HALVES), .b(t2), .vld(v2), .ctx(c2),
		.r(t3), .r_vld(v3), .r_ctx(c3)
	);

	// Update the estimate
	frs_fp_op u_upd (
		.clk(clk), .arst_n(arst_n), .en(en), .op(FOP_MUL),
		.a(c3.y), .b(t3), .vld(v3), .ctx(c3),
		.r(y_new), .r_vld(v4), .r_ctx(c4)
	);

	assign nxt_vld = v4;
	always_comb begin
		nxt_ctx = c4;
		nxt_ctx.y = y_new;
	end

endmodule

FILE: rtl/fast_rsqrt_recip_sqrt_unit.sv
// Top level of the fast inverse square root unit: seed, Newton cell chain, result select.
// Depends on frs_pkg, frs_if, frs_fp_op and frs_newton_cell.
//
//   channel | dir | payload                  | role
//   req     | in  | cmd[1:0], operand_bits   | one operand and command per request
//   rsp     | out | result_bits              | one binary32 result per request
//
// Fully pipelined: one request per cycle while not stalled. A request passes the halving
// multiply, the Newton cells, the final multiply and the output register in that order.
// The whole pipeline advances together; it stalls only while a result sits in the
// output register and rsp.ready is low, and req.ready follows that condition.
// Reset clears all valid bits; payload registers are not reset.

module fast_rsqrt_recip_sqrt_unit import frs_pkg::*; (
	input logic clk,
	input logic arst_n,
	frs_req_if.sink req,
	frs_rsp_if.source rsp
);

	logic adv;
	logic out_vld_q;
	logic [31:0] out_bits_q;

	ctx_t seed_ctx;
	ctx_t front_ctx_raw;
	ctx_t front_ctx;
	logic [31:0] hx;
	logic front_vld;

	ctx_t chain_ctx [NEWTON_STEPS + 1];
	logic chain_vld [NEWTON_STEPS + 1];

	ctx_t back_ctx;
	logic back_vld;
	logic [31:0] fin_a;
	logic [31:0] fin_r;
	logic [31:0] sel_bits;

	assign adv = !out_vld_q || rsp.ready;
	assign req.ready = adv;

	// Seed the estimate from the raw bits
	always_comb begin
		seed_ctx.cmd = req.cmd;
		seed_ctx.x = req.operand_bits;
		seed_ctx.hx = F32_POS_ZERO;
		seed_ctx.y = MAGIC_BASE - {1'b0, req.operand_bits[31:1]};
	end

	// Halve the operand
	frs_fp_op u_half (
		.clk(clk), .arst_n(arst_n), .en(adv), .op(FOP_MUL),
		.a(req.operand_bits), .b(F32_HALF), .vld(req.valid && req.ready),
		.ctx(seed_ctx), .r(hx), .r_vld(front_vld), .r_ctx(front_ctx_raw)
	);

	always_comb begin
		front_ctx = front_ctx_raw;
		front_ctx.hx = hx;
	end

	assign chain_ctx[0] = front_ctx;
	assign chain_vld[0] = front_vld;

	// Chain of refinement cells
	for (genvar k = 0; k < NEWTON_STEPS; k++) begin : g_cell
		frs_newton_cell u_cell (
			.clk(clk), .arst_n(arst_n), .en(adv),
			.vld(chain_vld[k]), .ctx(chain_ctx[k]),
			.nxt_vld(chain_vld[k + 1]), .nxt_ctx(chain_ctx[k + 1])
		);
	end

	// Final multiply: y*y for reciprocal, x*y for square root
	assign fin_a = (chain_ctx[NEWTON_STEPS].cmd == CMD_RECIP) ?
		chain_ctx[NEWTON_STEPS].y : chain_ctx[NEWTON_STEPS].x;

	frs_fp_op u_fin (
		.clk(clk), .arst_n(arst_n), .en(adv), .op(FOP_MUL),
		.a(fin_a), .b(chain_ctx[NEWTON_STEPS].y), .vld(chain_vld[NEWTON_STEPS]),
		.ctx(chain_ctx[NEWTON_STEPS]), .r(fin_r), .r_vld(back_vld), .r_ctx(back_ctx)
	);

	// Select by command and canonicalize NaN
	always_comb begin
		case (back_ctx.cmd)
			CMD_RSQRT: sel_bits = back_ctx.y;
			CMD_RECIP: sel_bits = fin_r;
			CMD_SQRT: sel_bits = fin_r;
			default: sel_bits = F32_POS_ZERO;
		endcase
		if ((sel_bits[30:23] == 8'hff) && (sel_bits[22:0] != 23'd0)) begin
			sel_bits = F32_CANON_NAN;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= back_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_bits_q <= sel_bits;
		end
	end

	assign rsp.valid = out_vld_q;
	assign rsp.result_bits = out_bits_q;

	// A waiting result blocks new requests
	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && !rsp.ready) |-> !req.ready)
		else $error("request taken while result stalled");

	// Any NaN leaves in canonical form
	a_canon_nan: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && (out_bits_q[30:23] == 8'hff) && (out_bits_q[22:0] != 23'd0))
		|-> (out_bits_q == F32_CANON_NAN))
		else $error("non-canonical NaN result");

	// A result appears only from a valid final stage
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_vld_q) |-> $past(back_vld))
		else $error("result valid without a request in the final stage");

endmodule

FILE: tb/frs_tb_if.sv
`timescale 1ns / 100ps
// Testbench side of the request and response channels.
// The channel interfaces themselves come from rtl/frs_if.sv; this file only
// holds the stimulus row type that the testbench top uses. Depends on nothing.

package frs_tb_pkg;

	// One row of the directed stimulus table
	typedef struct {
		logic [1:0] cmd;
		logic [31:0] x;
		bit known;
		logic [31:0] want;
	} stim_row_t;

endpackage

FILE: tb/fast_rsqrt_recip_sqrt_unit_tb.sv
`timescale 1ns / 100ps
// Testbench for fast_rsqrt_recip_sqrt_unit: directed table, then random requests
// under four idling phases, checked against a bit-exact binary32 predictor.
// Depends on frs_pkg, frs_if, frs_tb_pkg and the unit RTL.

module fast_rsqrt_recip_sqrt_unit_tb;
	import frs_pkg::*;
	import frs_tb_pkg::*;

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam logic [31:0] FP_NAN = 32'h7fc00000;
	localparam logic [31:0] FP_THREE_HALVES = 32'h3fc00000;
	localparam logic [31:0] FP_HALF = 32'h3f000000;
	localparam logic [31:0] RSQRT_SEED = 32'h5f3759df;
	localparam int REFINE_STEPS = 4;
	localparam int STALL_LIMIT = 5000;
	localparam int ITEMS_PER_PHASE = 350;

	logic clk;
	logic arst_n;

	frs_req_if req_if();
	frs_rsp_if rsp_if();

	fast_rsqrt_recip_sqrt_unit u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_if),
		.rsp(rsp_if)
	);

	logic [31:0] pending_results[$];
	int phase;
	int mismatches;
	int results_seen;
	int requests_sent;
	int cmd_count[4];
	int quiet_cycles;

	// Split a binary32 into an integer significand and the weight of its lsb
	function automatic void fp_split(input logic [31:0] f, output logic [63:0] sig,
			output int lsb_exp);
		if (f[30:23] == 8'd0) begin
			sig = {41'd0, f[22:0]};
			lsb_exp = -149;
		end else begin
			sig = {40'd0, 1'b1, f[22:0]};
			lsb_exp = int'(f[30:23]) - 150;
		end
	endfunction

	// Round sig * 2^lsb_exp to nearest even and pack as binary32
	function automatic logic [31:0] fp_round_pack(logic sgn, int lsb_exp, logic [63:0] sig);
		int p, sh, q, biased, i;
		logic [127:0] wide, m, rem, halfway;
		if (sig == 64'd0)
			return {sgn, 31'd0};
		p = 0;
		for (i = 0; i < 64; i++)
			if (sig[i])
				p = i;
		if (lsb_exp + p >= -126)
			sh = p - 23;
		else
			sh = -149 - lsb_exp;
		wide = {64'd0, sig};
		if (sh >= 100) begin
			m = '0;
		end else if (sh > 0) begin
			m = wide >> sh;
			rem = wide & ((128'd1 << sh) - 128'd1);
			halfway = 128'd1 << (sh - 1);
			if (rem > halfway || (rem == halfway && m[0]))
				m = m + 128'd1;
		end else begin
			m = wide << (-sh);
		end
		q = lsb_exp + sh;
		if (m[24]) begin
			m = m >> 1;
			q++;
		end
		if (m == '0)
			return {sgn, 31'd0};
		if (m[23]) begin
			biased = q + 150;
			if (biased >= 255)
				return {sgn, 8'hff, 23'd0};
			return {sgn, 8'(biased), m[22:0]};
		end
		return {sgn, 8'd0, m[22:0]};
	endfunction

	function automatic bit fp_is_nan(logic [31:0] f);
		return f[30:23] == 8'hff && f[22:0] != 23'd0;
	endfunction

	function automatic bit fp_is_inf(logic [31:0] f);
		return f[30:23] == 8'hff && f[22:0] == 23'd0;
	endfunction

	function automatic logic [31:0] fp_mul(logic [31:0] a, logic [31:0] b);
		logic [63:0] sa, sb;
		int ea, eb;
		logic sgn;
		sgn = a[31] ^ b[31];
		if (fp_is_nan(a) || fp_is_nan(b))
			return FP_NAN;
		if ((fp_is_inf(a) && b[30:0] == 31'd0) || (fp_is_inf(b) && a[30:0] == 31'd0))
			return FP_NAN;
		if (fp_is_inf(a) || fp_is_inf(b))
			return {sgn, 8'hff, 23'd0};
		fp_split(a, sa, ea);
		fp_split(b, sb, eb);
		return fp_round_pack(sgn, ea + eb, sa * sb);
	endfunction

	function automatic logic [31:0] fp_add(logic [31:0] a, logic [31:0] b);
		logic [63:0] sa, sb, big, sml, tmp;
		int ea, eb, d, te;
		logic sgn_a, sgn_b, tsg;
		if (fp_is_nan(a) || fp_is_nan(b))
			return FP_NAN;
		if (fp_is_inf(a) && fp_is_inf(b) && a[31] != b[31])
			return FP_NAN;
		if (fp_is_inf(a))
			return a;
		if (fp_is_inf(b))
			return b;
		if (a[30:0] == 31'd0 && b[30:0] == 31'd0)
			return {a[31] & b[31], 31'd0};
		fp_split(a, sa, ea);
		fp_split(b, sb, eb);
		sgn_a = a[31];
		sgn_b = b[31];
		// Keep the larger exponent in a
		if (ea < eb) begin
			tmp = sa; sa = sb; sb = tmp;
			te = ea; ea = eb; eb = te;
			tsg = sgn_a; sgn_a = sgn_b; sgn_b = tsg;
		end
		d = ea - eb;
		big = sa << 3;
		sml = sb << 3;
		if (d >= 40)
			sml = {63'd0, sb != 64'd0};
		else if (d > 0)
			sml = (sml >> d) | {63'd0, (sml & ((64'd1 << d) - 64'd1)) != 64'd0};
		if (sgn_a == sgn_b)
			return fp_round_pack(sgn_a, ea - 3, big + sml);
		if (big == sml)
			return 32'd0;
		if (big > sml)
			return fp_round_pack(sgn_a, ea - 3, big - sml);
		return fp_round_pack(sgn_b, ea - 3, sml - big);
	endfunction

	// Seed from the bit trick, refine, then pick the result the command asks for
	function automatic logic [31:0] predict_result(logic [1:0] cmd, logic [31:0] x);
		logic [31:0] half_x, y, t, r;
		int k;
		if (cmd == CMD_UNUSED)
			return 32'd0;
		half_x = fp_mul(x, FP_HALF);
		y = RSQRT_SEED - (x >> 1);
		for (k = 0; k < REFINE_STEPS; k++) begin
			t = fp_mul(y, y);
			t = fp_mul(half_x, t);
			t = fp_add(FP_THREE_HALVES, {~t[31], t[30:0]});
			y = fp_mul(y, t);
		end
		case (cmd)
			CMD_RSQRT: r = y;
			CMD_RECIP: r = fp_mul(y, y);
			default: r = fp_mul(x, y);
		endcase
		if (fp_is_nan(r))
			r = FP_NAN;
		return r;
	endfunction

	// Clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Receiver: stall according to the current phase
	always @(posedge clk) begin
		if (phase == 2)
			rsp_if.ready <= ($urandom_range(0, 99) >= 49);
		else if (phase == 3)
			rsp_if.ready <= ($urandom_range(0, 99) >= 14);
		else
			rsp_if.ready <= 1'b1;
	end

	// Check each response against the oldest pending result
	always @(posedge clk) begin
		logic [31:0] want;
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected response result_bits=%08h", rsp_if.result_bits);
			end else begin
				want = pending_results.pop_front();
				if (rsp_if.result_bits !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("response %0d: result_bits expected %08h got %08h",
							results_seen, want, rsp_if.result_bits);
				end
			end
		end
	end

	// Watchdog: count cycles with no handshake on either channel
	always @(posedge clk) begin
		if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("timeout: no handshake for %0d cycles", STALL_LIMIT);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Drive one request and hold it until accepted; record what it should return
	task automatic send_request(logic [1:0] cmd, logic [31:0] x, bit known, logic [31:0] want);
		logic [31:0] calc;
		while ((phase == 1 && $urandom_range(0, 99) < 49) ||
				(phase == 3 && $urandom_range(0, 99) < 14)) begin
			req_if.valid <= 1'b0;
			@(posedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.cmd <= cmd;
		req_if.operand_bits <= x;
		do
			@(posedge clk);
		while (!req_if.ready);
		calc = predict_result(cmd, x);
		if (known && calc !== want) begin
			mismatches++;
			if (mismatches <= 10)
				$display("predictor disagrees on cmd %0d x %08h: %08h vs %08h",
					cmd, x, calc, want);
		end
		pending_results.push_back(known ? want : calc);
		requests_sent++;
		cmd_count[cmd]++;
	endtask

	function automatic logic [31:0] random_operand();
		logic [31:0] x;
		x = $urandom();
		case ($urandom_range(0, 3))
			0: x[30:23] = 8'(100 + $urandom_range(0, 54));
			1: x = {1'b0, 8'(100 + $urandom_range(0, 54)), x[22:0]};
			2: x[30:23] = ($urandom_range(0, 1) != 0) ? 8'h00 : 8'hff;
			default: ;
		endcase
		return x;
	endfunction

	stim_row_t directed[] = '{
		'{CMD_UNUSED, 32'hffffffff, 1'b1, 32'h00000000},
		'{CMD_UNUSED, 32'h3f800000, 1'b1, 32'h00000000},
		'{CMD_RSQRT, 32'h7fc00001, 1'b1, FP_NAN},
		'{CMD_RECIP, 32'hffffffff, 1'b1, FP_NAN},
		'{CMD_SQRT, 32'h7f800001, 1'b1, FP_NAN},
		'{CMD_RSQRT, 32'h3f800000, 1'b0, 32'h0},
		'{CMD_RECIP, 32'h40800000, 1'b0, 32'h0},
		'{CMD_SQRT, 32'h40800000, 1'b0, 32'h0},
		'{CMD_RSQRT, 32'h00000000, 1'b0, 32'h0},
		'{CMD_SQRT, 32'h80000000, 1'b0, 32'h0},
		'{CMD_RECIP, 32'h00000000, 1'b0, 32'h0},
		'{CMD_RSQRT, 32'h7f800000, 1'b0, 32'h0},
		'{CMD_SQRT, 32'hff800000, 1'b0, 32'h0},
		'{CMD_RSQRT, 32'h7f7fffff, 1'b0, 32'h0},
		'{CMD_RECIP, 32'h7f7fffff, 1'b0, 32'h0},
		'{CMD_SQRT, 32'h00000001, 1'b0, 32'h0},
		'{CMD_RSQRT, 32'h00000001, 1'b0, 32'h0},
		'{CMD_RECIP, 32'h007fffff, 1'b0, 32'h0},
		'{CMD_SQRT, 32'h00800000, 1'b0, 32'h0},
		'{CMD_RSQRT, 32'hbf800000, 1'b0, 32'h0},
		'{CMD_SQRT, 32'h4b7fffff, 1'b0, 32'h0},
		'{CMD_RECIP, 32'h3e800000, 1'b0, 32'h0}
	};

	initial begin
		logic [1:0] cmd;
		int p, n;
		phase = 0;
		mismatches = 0;
		results_seen = 0;
		requests_sent = 0;
		quiet_cycles = 0;
		cmd_count = '{0, 0, 0, 0};
		arst_n = 1'b0;
		req_if.valid = 1'b0;
		req_if.cmd = CMD_RSQRT;
		req_if.operand_bits = 32'd0;
		rsp_if.ready = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the directed table
		foreach (directed[i])
			send_request(directed[i].cmd, directed[i].x, directed[i].known, directed[i].want);

		// Random requests, one block per idling phase
		for (p = 0; p < 4; p++) begin
			phase = p;
			for (n = 0; n < ITEMS_PER_PHASE; n++) begin
				cmd = ($urandom_range(0, 9) == 0) ? CMD_UNUSED : 2'($urandom_range(0, 2));
				send_request(cmd, random_operand(), 1'b0, 32'd0);
			end
		end
		req_if.valid <= 1'b0;

		// Drain the pipeline
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);

		$display("sent %0d requests (rsqrt %0d, recip %0d, sqrt %0d, unused %0d)",
			requests_sent, cmd_count[0], cmd_count[1], cmd_count[2], cmd_count[3]);
		$display("checked %0d responses over four idling phases, %0d mismatches",
			results_seen, mismatches);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
